// ===== src/heat_stencil_step_top_defines.svh =====
// assertion helpers for the stencil block
`ifndef HEAT_STENCIL_STEP_TOP_DEFINES_SVH
`define HEAT_STENCIL_STEP_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HSS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hss_pkg.sv =====
package hss_pkg;

  localparam int DATA_W     = 32;
  localparam int SUM_W      = 36;
  localparam int CFG_GRID_W = 11;
  localparam int CFG_GAIN_W = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_GRID_SIZE = 2'd0;
  localparam cfg_idx_t REG_DIFF_GAIN = 2'd1;

  localparam logic [CFG_GRID_W-1:0] GRID_SIZE_RST = 11'd1024;
  localparam logic [CFG_GAIN_W-1:0] DIFF_GAIN_RST = 25'd4194304;

endpackage

// ===== src/heat_stencil_step_top.sv =====
// heat_stencil_step_top: one explicit time step of the 2-D heat equation
// on a square grid streamed in raster order, boundary included.
// input channel: one sample per request (in_valid / in_stall), signed
// fixed point with FRAC_BITS fraction bits. output channel: one request
// per interior point (out_valid / out_stall) with the updated value, its
// row and column and a flag on the last interior point of the grid.
// configuration: cfg_valid / cfg_ready write of grid_size (index 0) and
// diffusion_gain (index 1); cfg_ready is always high. write only while
// the block holds no request in flight.
// throughput: one sample per cycle while in_stall is low. the row
// buffer is a single 64-bit memory (upper and middle row side by side)
// read once and written once per cycle; the stencil goes through a sum,
// multiply, round and saturate pipeline. out_valid rises once the result
// of the completing sample has passed the pipeline into the queue.
// a stalled receiver is absorbed by an 8-entry result queue; in_stall
// rises only when queue plus pipeline hold 8 pending results.
// reset: raster position to row 0 column 0, registers to grid_size 1024
// and gain 0.25, queue empty. row buffer contents are not cleared.
`include "heat_stencil_step_top_defines.svh"

module heat_stencil_step_top
  import hss_pkg::*;
#(
  parameter int MAX_GRID  = 1024,
  parameter int FRAC_BITS = 24,
  localparam int CW       = $clog2(MAX_GRID)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_new_value,
  output logic [CW-1:0]            out_row_index,
  output logic [CW-1:0]            out_col_index,
  output logic                     out_last_of_grid,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  cfg_idx_t                 cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int GW    = $clog2(MAX_GRID + 1);
  localparam int EW    = (GW > CFG_GRID_W) ? GW : CFG_GRID_W;
  localparam int PW    = 62;
  localparam int LO_W  = 18;
  localparam int HI_W  = SUM_W - LO_W;
  localparam int PLO_W = LO_W + CFG_GAIN_W;
  localparam int PHI_W = HI_W + CFG_GAIN_W + 1;
  localparam int CNT_W = FIFO_AW + 1;
  localparam logic signed [PW-1:0] HALF = PW'(64'd1 << (FRAC_BITS - 1));

  typedef struct packed {
    logic          emit;
    logic          last;
    logic [CW-1:0] row;
    logic [CW-1:0] col;
  } meta_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [CW-1:0]            row;
    logic [CW-1:0]            col;
    logic                     last;
  } res_t;

  // configuration
  logic [CFG_GRID_W-1:0] grid_size_r;
  logic [CFG_GAIN_W-1:0] diff_gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= GRID_SIZE_RST;
      diff_gain_r <= DIFF_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_GRID_SIZE) grid_size_r <= cfg_data[CFG_GRID_W-1:0];
      if (cfg_index == REG_DIFF_GAIN) diff_gain_r <= cfg_data[CFG_GAIN_W-1:0];
    end
  end

  // raster position
  logic [CW-1:0] col_count_r, col_count_nxt;
  logic [CW-1:0] row_count_r, row_count_nxt;
  logic [EW-1:0] g_eff, col_e, row_e, c_e, r_e;
  logic [CW-1:0] cur_addr;
  meta_t         meta0;
  logic          in_accept;

  always_comb begin
    g_eff = EW'(grid_size_r);
    if (g_eff < EW'(3)) g_eff = EW'(3);
    else if (g_eff > EW'(MAX_GRID)) g_eff = EW'(MAX_GRID);
    col_e = EW'(col_count_r);
    row_e = EW'(row_count_r);
    // a size change can leave the counters past the edge
    if (col_e >= g_eff) begin
      c_e = '0;
      r_e = row_e + EW'(1);
    end else begin
      c_e = col_e;
      r_e = row_e;
    end
    if (r_e >= g_eff) r_e = '0;
    cur_addr = c_e[CW-1:0];
    if (c_e + EW'(1) >= g_eff) begin
      col_count_nxt = '0;
      row_count_nxt = (r_e + EW'(1) >= g_eff) ? '0 : CW'(r_e + EW'(1));
    end else begin
      col_count_nxt = CW'(c_e + EW'(1));
      row_count_nxt = r_e[CW-1:0];
    end
    meta0.emit = (r_e >= EW'(2)) && (c_e >= EW'(2));
    meta0.last = (r_e == g_eff - EW'(1)) && (c_e == g_eff - EW'(1));
    meta0.row  = CW'(r_e - EW'(1));
    meta0.col  = CW'(c_e - EW'(1));
  end

  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (in_accept) begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
    end
  end

  // row buffer: {upper, middle} per column
  logic [2*DATA_W-1:0]      row_mem [MAX_GRID];
  logic [2*DATA_W-1:0]      rd_data_r;
  logic                     v1_r;
  meta_t                    meta1_r;
  logic [CW-1:0]            s1_addr_r;
  logic signed [DATA_W-1:0] s1_sample_r;

  always_ff @(posedge clk) begin
    if (in_accept) rd_data_r <= row_mem[cur_addr];
    if (v1_r) row_mem[s1_addr_r] <= {rd_data_r[DATA_W-1:0], s1_sample_r};
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      meta1_r     <= meta0;
      s1_addr_r   <= cur_addr;
      s1_sample_r <= in_sample;
    end
  end

  // window taps that the stencil still needs
  logic signed [DATA_W-1:0] win_up_r, win_mid1_r, win_mid2_r, win_lo_r;
  logic signed [SUM_W-1:0]  sum_s1;
  logic signed [DATA_W-1:0] right_s1;

  assign right_s1 = $signed(rd_data_r[DATA_W-1:0]);
  assign sum_s1 = SUM_W'(win_up_r) + SUM_W'(win_lo_r) + SUM_W'(win_mid1_r)
                + SUM_W'(right_s1) - (SUM_W'(win_mid2_r) <<< 2);

  always_ff @(posedge clk) begin
    if (v1_r) begin
      win_up_r   <= $signed(rd_data_r[2*DATA_W-1:DATA_W]);
      win_mid1_r <= win_mid2_r;
      win_mid2_r <= right_s1;
      win_lo_r   <= s1_sample_r;
    end
  end

  // arithmetic pipeline
  logic                     v2_r, v3_r, v4_r;
  meta_t                    meta2_r, meta3_r, meta4_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [DATA_W-1:0] center2_r, center3_r, center4_r;
  logic [PLO_W-1:0]         p_lo_r;
  logic signed [PHI_W-1:0]  p_hi_r;
  logic signed [PW-1:0]     prod_s3, delta_r, res_s4;
  logic signed [DATA_W-1:0] sat_s4;
  logic [PW-DATA_W:0]       hi_bits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_accept;
      v2_r <= v1_r && meta1_r.emit;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    meta2_r   <= meta1_r;
    meta3_r   <= meta2_r;
    meta4_r   <= meta3_r;
    sum_r     <= sum_s1;
    center2_r <= win_mid2_r;
    center3_r <= center2_r;
    center4_r <= center3_r;
    // partial products keep each multiplier near 18 by 26
    p_lo_r    <= sum_r[LO_W-1:0] * diff_gain_r;
    p_hi_r    <= $signed(sum_r[SUM_W-1:LO_W]) * $signed({1'b0, diff_gain_r});
    delta_r   <= prod_s3 >>> FRAC_BITS;
  end

  assign prod_s3 = (PW'(p_hi_r) <<< LO_W) + $signed({{(PW-PLO_W){1'b0}}, p_lo_r}) + HALF;
  assign res_s4  = PW'(center4_r) + delta_r;
  assign hi_bits = res_s4[PW-1:DATA_W-1];

  always_comb begin
    if (hi_bits == '0 || hi_bits == '1) sat_s4 = res_s4[DATA_W-1:0];
    else if (res_s4[PW-1]) sat_s4 = {1'b1, {(DATA_W-1){1'b0}}};
    else sat_s4 = {1'b0, {(DATA_W-1){1'b1}}};
  end

  // result queue
  res_t               fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   fifo_cnt_r, occupancy;
  logic [2:0]         pending;
  logic               push, pop;
  res_t               push_data;

  assign push = v4_r;
  assign pop  = out_valid && !out_stall;

  assign push_data.value = sat_s4;
  assign push_data.row   = meta4_r.row;
  assign push_data.col   = meta4_r.col;
  assign push_data.last  = meta4_r.last;

  always_ff @(posedge clk) begin
    if (push) fifo_mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      unique case ({push, pop})
        2'b10:   fifo_cnt_r <= fifo_cnt_r + CNT_W'(1);
        2'b01:   fifo_cnt_r <= fifo_cnt_r - CNT_W'(1);
        default: fifo_cnt_r <= fifo_cnt_r;
      endcase
    end
  end

  // results still in the pipeline hold a queue slot
  assign pending   = 3'(v1_r && meta1_r.emit) + 3'(v2_r) + 3'(v3_r) + 3'(v4_r);
  assign occupancy = fifo_cnt_r + CNT_W'(pending);
  assign in_stall  = occupancy >= CNT_W'(FIFO_DEPTH);

  assign out_valid        = fifo_cnt_r != '0;
  assign out_new_value    = fifo_mem[rd_ptr_r].value;
  assign out_row_index    = fifo_mem[rd_ptr_r].row;
  assign out_col_index    = fifo_mem[rd_ptr_r].col;
  assign out_last_of_grid = fifo_mem[rd_ptr_r].last;

  `HSS_ASSERT_SAME(a_no_same_entry, in_accept && v1_r, cur_addr != s1_addr_r,
    "row buffer read and write hit the same column")
  `HSS_ASSERT_SAME(a_slots_bounded, 1'b1, occupancy <= CNT_W'(FIFO_DEPTH),
    "queue plus pipeline exceed the queue depth")
  `HSS_ASSERT_SAME(a_no_overflow, push && !pop, fifo_cnt_r != CNT_W'(FIFO_DEPTH),
    "result pushed into a full queue")
  `HSS_ASSERT_NEXT(a_accept_enters, in_accept, v1_r,
    "accepted sample did not enter the pipeline")
  `HSS_ASSERT_SAME(a_last_diag, out_valid && out_last_of_grid,
    out_row_index == out_col_index, "last point is off the diagonal")

endmodule

// ===== tb/heat_stencil_step_checker.sv =====
module heat_stencil_step_checker
  import hss_pkg::*;
#(
  parameter int MAX_GRID  = 1024,
  parameter int FRAC_BITS = 24,
  localparam int CW       = $clog2(MAX_GRID)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_sample,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] out_new_value,
  input  logic [CW-1:0]            out_row_index,
  input  logic [CW-1:0]            out_col_index,
  input  logic                     out_last_of_grid,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  cfg_idx_t                 cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output int                       mismatch_count,
  output int                       points_due
);

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [CW-1:0]            row;
    logic [CW-1:0]            col;
    logic                     last;
  } grid_point_t;

  logic [CFG_GRID_W-1:0]    grid_reg;
  logic [CFG_GAIN_W-1:0]    gain_reg;
  logic signed [DATA_W-1:0] upper_row [MAX_GRID];
  logic signed [DATA_W-1:0] middle_row [MAX_GRID];
  logic signed [DATA_W-1:0] win [9];
  int                       col_pos;
  int                       row_pos;
  grid_point_t              updated_points [$];

  function automatic int grid_span();
    if (grid_reg < 3) return 3;
    if (grid_reg > MAX_GRID) return MAX_GRID;
    return int'(grid_reg);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, what);
  endtask

  // one raster sample through the row stores and the 3x3 window
  task automatic jacobi_update(input logic signed [DATA_W-1:0] val);
    int          g;
    longint      center;
    longint      lap;
    longint      delta;
    longint      res;
    grid_point_t p;
    g = grid_span();
    if (col_pos >= g) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= g) row_pos = 0;
    for (int k = 0; k < 3; k++) begin
      win[3*k]   = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = upper_row[col_pos];
    win[5] = middle_row[col_pos];
    win[8] = val;
    upper_row[col_pos]  = middle_row[col_pos];
    middle_row[col_pos] = val;
    if (row_pos >= 2 && col_pos >= 2) begin
      center = longint'(win[4]);
      lap    = longint'(win[1]) + longint'(win[7]) + longint'(win[3])
             + longint'(win[5]) - 4 * center;
      // round half up, then floor through the arithmetic shift
      delta  = (lap * longint'(gain_reg) + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      res    = center + delta;
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      p.value = res[DATA_W-1:0];
      p.row   = CW'(row_pos - 1);
      p.col   = CW'(col_pos - 1);
      p.last  = (row_pos == g - 1) && (col_pos == g - 1);
      updated_points = {updated_points, p};
    end
    if (col_pos + 1 >= g) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= g) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  always @(posedge clk) begin : watch
    grid_point_t want;
    if (!rst_n) begin
      grid_reg = GRID_SIZE_RST;
      gain_reg = DIFF_GAIN_RST;
      foreach (upper_row[i]) upper_row[i] = '0;
      foreach (middle_row[i]) middle_row[i] = '0;
      foreach (win[i]) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      updated_points.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRID_SIZE: grid_reg = cfg_data[CFG_GRID_W-1:0];
          REG_DIFF_GAIN: gain_reg = cfg_data[CFG_GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) jacobi_update(in_sample);
      if (out_valid && !out_stall) begin
        if (updated_points.size() == 0) begin
          flag_mismatch($sformatf("result with none pending: value %0d row %0d col %0d last %0b",
                                  out_new_value, out_row_index, out_col_index,
                                  out_last_of_grid));
        end else begin
          want = updated_points.pop_front();
          if (out_new_value !== want.value || out_row_index !== want.row ||
              out_col_index !== want.col || out_last_of_grid !== want.last) begin
            flag_mismatch($sformatf(
              "expected value %0d row %0d col %0d last %0b, got value %0d row %0d col %0d last %0b",
              want.value, want.row, want.col, want.last,
              out_new_value, out_row_index, out_col_index, out_last_of_grid));
          end
        end
      end
    end
    points_due = updated_points.size();
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import hss_pkg::*;

  localparam int MAX_GRID = 1024;
  localparam int CW       = $clog2(MAX_GRID);
  localparam int ITEMS    = 1100;

  // index with no register behind it, writes to it are ignored
  localparam cfg_idx_t REG_SPARE = 2'd3;

  localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] HALF_LSB   = 32'sd8388608;
  localparam logic [CFG_DATA_W-1:0]    GAIN_ONE   = 25'd16777216;
  localparam logic [CFG_DATA_W-1:0]    GAIN_TOP   = '1;
  localparam logic [CFG_DATA_W-1:0]    GRID_TOP   = 25'd2047;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_sample = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_new_value;
  logic [CW-1:0]            out_row_index;
  logic [CW-1:0]            out_col_index;
  logic                     out_last_of_grid;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  cfg_idx_t                 cfg_index = REG_GRID_SIZE;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  int mismatch_count;
  int points_due;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int span = MAX_GRID;
  int col_at = 0;
  int row_at = 0;
  int sent = 0;

  always #5 clk = ~clk;

  heat_stencil_step_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_new_value    (out_new_value),
    .out_row_index    (out_row_index),
    .out_col_index    (out_col_index),
    .out_last_of_grid (out_last_of_grid),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  heat_stencil_step_checker #(.MAX_GRID(MAX_GRID)) scoreboard (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_new_value    (out_new_value),
    .out_row_index    (out_row_index),
    .out_col_index    (out_col_index),
    .out_last_of_grid (out_last_of_grid),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .points_due       (points_due)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic set_mode(input int m);
    case (m)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
      default: begin send_idle_pct = 21; recv_stall_pct = 21; end
    endcase
  endtask

  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3, 4: return $signed($urandom_range(0, 32'h03FF_FFFF)) - 32'sh0200_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return GAIN_ONE;
      2: return GAIN_TOP;
      3: return DIFF_GAIN_RST;
      4: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(0, DIFF_GAIN_RST));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_grid();
    case ($urandom_range(0, 15))
      0: return CFG_DATA_W'($urandom_range(0, 2));
      1: return CFG_DATA_W'($urandom_range(11, 14));
      default: return CFG_DATA_W'($urandom_range(3, 10));
    endcase
  endfunction

  // one request on the sample channel, with the raster position tracked
  task automatic send(input logic signed [DATA_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= val;
    do @(posedge clk); while (in_stall);
    if (col_at >= span) begin
      col_at = 0;
      row_at++;
    end
    if (row_at >= span) row_at = 0;
    if (col_at + 1 >= span) begin
      col_at = 0;
      row_at = (row_at + 1 >= span) ? 0 : row_at + 1;
    end else begin
      col_at++;
    end
    sent++;
  endtask

  task automatic finish_grid();
    while (col_at != 0 || row_at != 0) send(pick_sample());
  endtask

  // drain all pending results, then give the pipeline time to empty
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (points_due != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    int g;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_GRID_SIZE) begin
      g = int'(val[CFG_GRID_W-1:0]);
      span = (g < 3) ? 3 : (g > MAX_GRID) ? MAX_GRID : g;
    end
    @(posedge clk);
  endtask

  initial begin : stimulus
    int phase;
    int grids;
    logic signed [DATA_W-1:0] val;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset grid size: the start of the first row fills the stores
    set_mode(3);
    repeat (40) send(pick_sample());
    settle();
    // oversize grid value keeps the full width
    write_reg(REG_GRID_SIZE, GRID_TOP);
    repeat (40) send(pick_sample());
    settle();
    // shrink mid-grid, position wraps to the next row
    write_reg(REG_GRID_SIZE, 25'd6);
    finish_grid();
    settle();

    // 3x3 grid (size below minimum), gain above one, saturates high
    set_mode(0);
    write_reg(REG_GRID_SIZE, '0);
    write_reg(REG_DIFF_GAIN, GAIN_TOP);
    write_reg(REG_SPARE, '1);
    for (int i = 0; i < 9; i++) send((i == 4) ? SAMPLE_MIN : SAMPLE_MAX);
    settle();

    // gain of one lsb: rounding ties up, exact tie down to zero, just below a tie
    write_reg(REG_GRID_SIZE, 25'd4);
    write_reg(REG_DIFF_GAIN, 25'd1);
    for (int i = 0; i < 16; i++) begin
      case (i)
        1:  val = HALF_LSB;
        2:  val = -HALF_LSB;
        13: val = -HALF_LSB - 1;
        default: val = '0;
      endcase
      send(val);
    end
    settle();

    phase = 0;
    while (sent < ITEMS - 50) begin
      set_mode(phase % 4);
      phase++;
      if ($urandom_range(0, 3) != 0) write_reg(REG_GRID_SIZE, pick_grid());
      if ($urandom_range(0, 2) != 0) write_reg(REG_DIFF_GAIN, pick_gain());
      if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
      grids = (span > 10) ? 1 : $urandom_range(1, 3);
      repeat (grids * span * span) send(pick_sample());
      if (span > 3 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, span * span - 1)) send(pick_sample());
        settle();
        write_reg(REG_GRID_SIZE, CFG_DATA_W'($urandom_range(0, span - 1)));
        finish_grid();
      end
      settle();
    end

    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
